// ===== design/ftp_pkg.sv =====
// ----------------------------------------------------------------------------
// ftp_pkg
// Shared types and constants for the frame-time profiler: field widths,
// register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package ftp_pkg;

    localparam int TimeW   = 24;
    localparam int CountW  = 32;
    localparam int BatchW  = 8;
    localparam int CfgAddrW = 1;
    localparam int CfgDataW = 8;
    localparam int InDataW  = 32;
    localparam int OutDataW = 280;
    localparam int StepW    = 5;

    localparam logic [CfgAddrW-1:0] REG_BATCH_LEN = 1'b0;
    localparam logic [CfgAddrW-1:0] REG_STREAM_EN = 1'b1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } t_ftp_state;

    typedef struct packed {
        logic load;      // capture the input word
        logic update;    // apply sample or clear to the statistics
        logic div_step;  // one restoring division step
        logic out_load;  // move the finished result into the output register
    } t_ftp_cmd;

    typedef struct packed {
        logic report;    // the item being updated closes a batch
    } t_ftp_stat;

endpackage

// ===== design/ftp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftp_ctrl
// Controller: sequences capture, update, the serial divide for the batch
// average and the hand-over to the output register; owns the output valid.
// ----------------------------------------------------------------------------
module ftp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  ftp_pkg::t_ftp_stat i_stat,
    output ftp_pkg::t_ftp_cmd  o_cmd
);
    import ftp_pkg::*;

    t_ftp_state       r_state;
    t_ftp_state       n_state;
    logic [StepW-1:0] r_step;
    logic [StepW-1:0] n_step;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_slot_free;
    logic             w_last_step;

    assign w_slot_free = !r_out_valid || i_m_tready;
    assign w_last_step = (r_step == {StepW{1'b1}});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = i_stat.report ? ST_DIVIDE : ST_EMIT;
            end
            ST_DIVIDE: begin
                if (w_last_step) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // hold off the sender while in reset
                o_s_tready = i_rst_n;
                o_cmd.load = i_s_tvalid && i_rst_n;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.out_load = w_slot_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (o_cmd.update)   n_step = '0;
        if (o_cmd.div_step) n_step = r_step + 1'b1;
        n_out_valid = r_out_valid;
        if (i_m_tready)     n_out_valid = 1'b0;
        if (o_cmd.out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

// ===== design/ftp_datapath.sv =====
// ----------------------------------------------------------------------------
// ftp_datapath
// Datapath: configuration registers, lifetime and batch statistics, the
// restoring 32-bit divider for the batch average and the output register.
// ----------------------------------------------------------------------------
module ftp_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ftp_pkg::CfgAddrW-1:0]    i_cfg_addr,
    input  logic [ftp_pkg::CfgDataW-1:0]    i_cfg_data,
    input  logic [ftp_pkg::InDataW-1:0]     i_s_tdata,
    input  logic                            i_s_tuser,
    output logic [ftp_pkg::OutDataW-1:0]    o_m_tdata,
    output logic                            o_m_tuser,
    input  ftp_pkg::t_ftp_cmd               i_cmd,
    output ftp_pkg::t_ftp_stat              o_stat
);
    import ftp_pkg::*;

    // configuration
    logic [BatchW-1:0] r_batch_len;
    logic              r_stream_en;

    // captured input word
    logic              r_cmd;
    logic [TimeW-1:0]  r_time;
    logic              r_ovr;

    // lifetime set
    logic [TimeW-1:0]  r_l_min,  n_l_min;
    logic [TimeW-1:0]  r_l_max,  n_l_max;
    logic [CountW-1:0] r_l_sum,  n_l_sum;
    logic [CountW-1:0] r_l_cnt,  n_l_cnt;
    logic [CountW-1:0] r_l_ovr,  n_l_ovr;

    // batch set
    logic [TimeW-1:0]  r_w_min,  n_w_min;
    logic [TimeW-1:0]  r_w_max,  n_w_max;
    logic [CountW-1:0] r_w_sum,  n_w_sum;
    logic [CountW-1:0] r_w_cnt,  n_w_cnt;
    logic [CountW-1:0] r_w_ovr,  n_w_ovr;

    // report snapshot and divider
    logic              r_rep;
    logic [CountW-1:0] r_rep_frames;
    logic [TimeW-1:0]  r_rep_min;
    logic [TimeW-1:0]  r_rep_max;
    logic [CountW-1:0] r_rep_ovr;
    logic [CountW-1:0] r_rem;
    logic [CountW-1:0] r_quo;
    logic [CountW-1:0] r_div;
    logic [CountW:0]   w_trial;
    logic              w_fits;
    logic              w_report;

    logic [OutDataW-1:0] r_out_data;
    logic                r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_len <= BatchW'(1);
            r_stream_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_BATCH_LEN: begin
                    // drop a zero batch size
                    if (i_cfg_data != '0) r_batch_len <= i_cfg_data[BatchW-1:0];
                end
                REG_STREAM_EN: r_stream_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_s_tuser;
            r_time <= i_s_tdata[TimeW-1:0];
            r_ovr  <= i_s_tdata[TimeW];
        end
    end

    // sample applied to both sets; a zero count seeds min and max
    always_comb begin
        n_l_min = (r_l_cnt == '0 || r_time < r_l_min) ? r_time : r_l_min;
        n_l_max = (r_l_cnt == '0 || r_time > r_l_max) ? r_time : r_l_max;
        n_l_sum = r_l_sum + CountW'(r_time);
        n_l_cnt = r_l_cnt + 1'b1;
        n_l_ovr = r_l_ovr + CountW'(r_ovr);
        n_w_min = (r_w_cnt == '0 || r_time < r_w_min) ? r_time : r_w_min;
        n_w_max = (r_w_cnt == '0 || r_time > r_w_max) ? r_time : r_w_max;
        n_w_sum = r_w_sum + CountW'(r_time);
        n_w_cnt = r_w_cnt + 1'b1;
        n_w_ovr = r_w_ovr + CountW'(r_ovr);
    end

    assign w_report = (r_cmd == CMD_SAMPLE) && r_stream_en &&
                      (n_w_cnt >= CountW'(r_batch_len)) && (n_w_cnt != '0);
    assign o_stat.report = w_report;

    assign w_trial = {r_rem, r_quo[CountW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_min <= '0; r_l_max <= '0; r_l_sum <= '0; r_l_cnt <= '0; r_l_ovr <= '0;
            r_w_min <= '0; r_w_max <= '0; r_w_sum <= '0; r_w_cnt <= '0; r_w_ovr <= '0;
        end else if (i_cmd.update) begin
            if (r_cmd == CMD_CLEAR) begin
                r_l_min <= '0; r_l_max <= '0; r_l_sum <= '0; r_l_cnt <= '0;
                r_l_ovr <= '0;
                r_w_min <= '0; r_w_max <= '0; r_w_sum <= '0; r_w_cnt <= '0;
                r_w_ovr <= '0;
            end else begin
                r_l_min <= n_l_min; r_l_max <= n_l_max; r_l_sum <= n_l_sum;
                r_l_cnt <= n_l_cnt; r_l_ovr <= n_l_ovr;
                if (w_report) begin
                    // batch goes to the report; start a fresh one
                    r_w_min <= '0; r_w_max <= '0; r_w_sum <= '0; r_w_cnt <= '0;
                    r_w_ovr <= '0;
                end else begin
                    r_w_min <= n_w_min; r_w_max <= n_w_max; r_w_sum <= n_w_sum;
                    r_w_cnt <= n_w_cnt; r_w_ovr <= n_w_ovr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rep <= w_report;
            r_rem <= '0;
            if (w_report) begin
                r_rep_frames <= n_w_cnt;
                r_rep_min    <= n_w_min;
                r_rep_max    <= n_w_max;
                r_rep_ovr    <= n_w_ovr;
                r_quo        <= n_w_sum;
                r_div        <= n_w_cnt;
            end else begin
                r_rep_frames <= '0;
                r_rep_min    <= '0;
                r_rep_max    <= '0;
                r_rep_ovr    <= '0;
                r_quo        <= '0;
                r_div        <= '0;
            end
        end else if (i_cmd.div_step) begin
            // shift the next dividend bit in, subtract where it fits
            r_rem <= w_fits ? CountW'(w_trial - {1'b0, r_div}) : w_trial[CountW-1:0];
            r_quo <= {r_quo[CountW-2:0], w_fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_user <= r_rep;
            r_out_data <= {r_l_ovr, r_l_cnt, r_l_sum, r_l_max, r_l_min,
                           r_rep_ovr, r_rep_max, r_rep_min, r_quo[TimeW-1:0],
                           r_rep_frames};
        end
    end

    assign o_m_tdata = r_out_data;
    assign o_m_tuser = r_out_user;

endmodule

// ===== design/frame_time_profiler.sv =====
// ----------------------------------------------------------------------------
// frame_time_profiler
// Flow: capture, update, then for a closing batch the 32 steps of the serial
// divider for the batch average, then hand-over to the output register.
// A new word is accepted only once the previous result is in that register.
// Reset: batch length 1, streaming off, all statistics zero, output empty.
// Frame-time statistics, lifetime and per batch, with batch reports.
// ----------------------------------------------------------------------------
module frame_time_profiler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ftp_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  logic [ftp_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // frame_time [23:0], overrun [24], zero [31:25]
    input  logic [ftp_pkg::InDataW-1:0]   i_s_tdata,
    // cmd
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // batch_frames [31:0], batch_average [55:32], batch_minimum [79:56],
    // batch_maximum [103:80], batch_overruns [135:104], life_minimum [159:136],
    // life_maximum [183:160], life_sum [215:184], life_frames [247:216],
    // life_overruns [279:248]
    output logic [ftp_pkg::OutDataW-1:0]  o_m_tdata,
    // report_valid
    output logic                          o_m_tuser
);
    import ftp_pkg::*;

    t_ftp_cmd  w_cmd;
    t_ftp_stat w_stat;

    ftp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ftp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule
